[rtl/scba_pkg.sv]
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types, register indexes, operation and status codes and reset
// values for the size-class buffer allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

  // Defaults for the top-level parameters
  localparam int CLASS_DEPTH_DEF = 256;
  localparam int SIZE_BITS_DEF   = 16;

  // Fixed field widths
  localparam int NCLASS    = 4;
  localparam int CLASS_W   = 2;
  localparam int HANDLE_W  = 10;
  localparam int TOTAL_W   = 11;
  localparam int CNT_W     = 9;
  localparam int SIZE_W    = 16;
  localparam int REQ_W     = 32;
  localparam int SLOT_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_SIZE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_SIZE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUGE_SIZE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_COUNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_COUNT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_COUNT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HUGE_COUNT   = 3'd7;

  // Register reset values
  localparam logic [SIZE_W-1:0] SMALL_SIZE_RST  = 16'd64;
  localparam logic [SIZE_W-1:0] MEDIUM_SIZE_RST = 16'd256;
  localparam logic [SIZE_W-1:0] LARGE_SIZE_RST  = 16'd1024;
  localparam logic [SIZE_W-1:0] HUGE_SIZE_RST   = 16'd8192;
  localparam logic [CNT_W-1:0]  COUNT_RST       = 9'd64;

  // Operation codes
  localparam logic FUNC_ACQUIRE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS       = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_HANDLE = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NULL       = 3'd4;

  // Controller states
  typedef enum logic [1:0] {
    ST_FILL,
    ST_IDLE,
    ST_BUSY
  } st_t;

endpackage

[rtl/scba_ram.sv]
// ----------------------------------------------------------------------------
// scba_ram
// Generic single-clock RAM, one write port and one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
module scba_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/size_class_buffer_allocator.sv]
// ----------------------------------------------------------------------------
// size_class_buffer_allocator
// Packet-buffer handle manager with four size classes, each a FIFO free
// list kept in one shared RAM.
// ----------------------------------------------------------------------------
// Each acquire or release transaction has an accept cycle, which picks the
// class, updates the list pointers and issues the free-list RAM access, and
// a result step, which takes the registered RAM read data and loads the
// result register. A new transaction is taken while the previous result
// still waits in the output register; the input stalls during the result
// step, which is held while that register is full and out_stall is high.
// After reset and after every configuration write the lists are rebuilt in
// the ST_FILL state, during which no transaction is accepted: a free-list
// entry not overwritten since the rebuild reads as its initial handle,
// decided by a per-class count of such writes, so the RAM needs no sweep.
// ----------------------------------------------------------------------------
module size_class_buffer_allocator #(
  parameter int CLASS_DEPTH = scba_pkg::CLASS_DEPTH_DEF,
  parameter int SIZE_BITS   = scba_pkg::SIZE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [scba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scba_pkg::CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [scba_pkg::REQ_W-1:0]     in_request_size,
  input  logic                           in_handle_valid,
  input  logic [scba_pkg::HANDLE_W-1:0]  in_release_handle,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_granted,
  output logic [scba_pkg::HANDLE_W-1:0]  out_grant_handle,
  output logic [scba_pkg::CLASS_W-1:0]   out_grant_class,
  output logic [scba_pkg::SLOT_W-1:0]    out_grant_slot,
  output logic [scba_pkg::SIZE_W-1:0]    out_grant_capacity,
  output logic [scba_pkg::STATUS_W-1:0]  out_status,
  output logic                           out_huge_available
);

  import scba_pkg::*;

  localparam int PTR_W   = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
  localparam int OCC_W   = $clog2(CLASS_DEPTH + 1);
  localparam int ADDR_W  = CLASS_W + PTR_W;
  localparam int RAM_DEPTH = NCLASS << PTR_W;
  localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(CLASS_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(CLASS_DEPTH - 1);
  localparam logic [SIZE_W-1:0] SIZE_MASK =
    (SIZE_BITS >= SIZE_W) ? {SIZE_W{1'b1}} : SIZE_W'((64'd1 << SIZE_BITS) - 64'd1);

  // --------------------------------------------------------------------------
  // Configuration and list state
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0]  size_r  [NCLASS];
  logic [CNT_W-1:0]   count_r [NCLASS];
  logic [PTR_W-1:0]   head_r  [NCLASS];
  logic [PTR_W-1:0]   head_nxt[NCLASS];
  logic [PTR_W-1:0]   tail_r  [NCLASS];
  logic [PTR_W-1:0]   tail_nxt[NCLASS];
  logic [OCC_W-1:0]   occ_r   [NCLASS];
  logic [OCC_W-1:0]   occ_nxt [NCLASS];
  logic [OCC_W-1:0]   wcnt_r  [NCLASS];   // writes since rebuild, saturating
  logic [OCC_W-1:0]   wcnt_nxt[NCLASS];

  st_t st_r, st_nxt;

  // derived from configuration
  logic [CNT_W-1:0]   eff     [NCLASS];
  logic [TOTAL_W-1:0] base    [NCLASS+1];
  logic [PTR_W-1:0]   tail0   [NCLASS];

  always_comb begin
    for (int c = 0; c < NCLASS; c++) begin
      eff[c] = (32'(count_r[c]) > CLASS_DEPTH) ? CNT_W'(CLASS_DEPTH) : count_r[c];
      tail0[c] = (32'(eff[c]) >= CLASS_DEPTH) ? '0 : PTR_W'(eff[c]);
    end
    base[0] = '0;
    for (int c = 0; c < NCLASS; c++) begin
      base[c+1] = base[c] + TOTAL_W'(eff[c]);
    end
  end

  function automatic logic [CLASS_W-1:0] own_class(input logic [TOTAL_W-1:0] h,
                                                   input logic [TOTAL_W-1:0] b1,
                                                   input logic [TOTAL_W-1:0] b2,
                                                   input logic [TOTAL_W-1:0] b3);
    logic [CLASS_W-1:0] k;
    k = 2'd0;
    if (h >= b1) k = 2'd1;
    if (h >= b2) k = 2'd2;
    if (h >= b3) k = 2'd3;
    return k;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  logic accept;
  logic finish;
  logic out_valid_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_FILL: st_nxt = ST_IDLE;
      ST_IDLE: if (accept) st_nxt = ST_BUSY;
      ST_BUSY: if (finish) st_nxt = ST_IDLE;
      default: st_nxt = ST_FILL;
    endcase
    if (cfg_we) begin
      st_nxt = ST_FILL;
    end
  end

  always_comb begin
    in_stall = 1'b1;
    finish   = 1'b0;
    unique case (st_r)
      ST_FILL: in_stall = 1'b1;
      ST_IDLE: in_stall = 1'b0;
      ST_BUSY: finish   = !out_valid_r || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Accept cycle: class choice, pointer update, RAM access
  // --------------------------------------------------------------------------
  logic [NCLASS-1:0]   hit;
  logic                any_hit;
  logic [CLASS_W-1:0]  sel;
  logic [PTR_W-1:0]    rd_ptr;
  logic [OCC_W-1:0]    head_ofs;
  logic                ovw;
  logic [HANDLE_W-1:0] fill_val;
  logic [TOTAL_W-1:0]  rel_h;
  logic [CLASS_W-1:0]  rel_own;
  logic [CLASS_W-1:0]  dst;
  logic                dst_full;
  logic                is_acq;
  logic                ram_re;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [HANDLE_W-1:0] ram_rdata;
  logic [STATUS_W-1:0] acc_status;

  always_comb begin
    is_acq = (in_func == FUNC_ACQUIRE);

    hit = '0;
    for (int c = 0; c < NCLASS; c++) begin
      hit[c] = (in_request_size <= REQ_W'(size_r[c])) && (occ_r[c] != '0);
    end
    any_hit = |hit;
    sel = '0;
    for (int c = NCLASS - 1; c >= 0; c--) begin
      if (hit[c]) sel = CLASS_W'(c);
    end

    // entry at the head still holds its rebuild handle unless the tail has
    // since written over it
    rd_ptr = head_r[sel];
    if (rd_ptr >= tail0[sel]) begin
      head_ofs = OCC_W'(rd_ptr) - OCC_W'(tail0[sel]);
    end else begin
      head_ofs = OCC_W'(rd_ptr) + DEPTH_OCC - OCC_W'(tail0[sel]);
    end
    ovw      = head_ofs < wcnt_r[sel];
    fill_val = HANDLE_W'(base[sel] + TOTAL_W'(rd_ptr));

    rel_h   = TOTAL_W'(in_release_handle);
    rel_own = own_class(rel_h, base[1], base[2], base[3]);
    dst = rel_own;
    for (int c = NCLASS - 1; c >= 0; c--) begin
      if (size_r[c] == size_r[rel_own]) dst = CLASS_W'(c);
    end
    dst_full = occ_r[dst] >= DEPTH_OCC;

    if (is_acq) begin
      acc_status = any_hit ? STAT_OK : STAT_MISS;
    end else if (!in_handle_valid) begin
      acc_status = STAT_NULL;
    end else if (rel_h >= base[NCLASS]) begin
      acc_status = STAT_BAD_HANDLE;
    end else if (dst_full) begin
      acc_status = STAT_FULL;
    end else begin
      acc_status = STAT_OK;
    end

    ram_re    = accept && is_acq && any_hit;
    ram_we    = accept && !is_acq && (acc_status == STAT_OK);
    ram_raddr = {sel, rd_ptr};
    ram_waddr = {dst, tail_r[dst]};
  end

  always_comb begin
    for (int c = 0; c < NCLASS; c++) begin
      head_nxt[c] = head_r[c];
      tail_nxt[c] = tail_r[c];
      occ_nxt[c]  = occ_r[c];
      wcnt_nxt[c] = wcnt_r[c];
      if (st_r == ST_FILL) begin
        head_nxt[c] = '0;
        tail_nxt[c] = tail0[c];
        occ_nxt[c]  = OCC_W'(eff[c]);
        wcnt_nxt[c] = '0;
      end else begin
        if (ram_re && (sel == CLASS_W'(c))) begin
          head_nxt[c] = ptr_inc(head_r[c]);
          occ_nxt[c]  = occ_r[c] - OCC_W'(1);
        end
        if (ram_we && (dst == CLASS_W'(c))) begin
          tail_nxt[c] = ptr_inc(tail_r[c]);
          occ_nxt[c]  = occ_r[c] + OCC_W'(1);
          if (wcnt_r[c] != DEPTH_OCC) begin
            wcnt_nxt[c] = wcnt_r[c] + OCC_W'(1);
          end
        end
      end
    end
  end

  scba_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_free_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_release_handle),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Result step: resolve handle, load result register
  // --------------------------------------------------------------------------
  logic                pend_grant_r;
  logic [STATUS_W-1:0] pend_status_r;
  logic                pend_ovw_r;
  logic [HANDLE_W-1:0] pend_fill_r;

  logic [HANDLE_W-1:0] gh;
  logic [CLASS_W-1:0]  g_own;
  logic [TOTAL_W-1:0]  g_slot;

  logic                granted_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [CLASS_W-1:0]  class_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [SIZE_W-1:0]   cap_r;
  logic [STATUS_W-1:0] status_r;
  logic                huge_r;

  always_comb begin
    gh     = pend_ovw_r ? ram_rdata : pend_fill_r;
    g_own  = own_class(TOTAL_W'(gh), base[1], base[2], base[3]);
    g_slot = TOTAL_W'(gh) - base[g_own];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_grant_r  <= is_acq && any_hit;
      pend_status_r <= acc_status;
      pend_ovw_r    <= ovw;
      pend_fill_r   <= fill_val;
    end
    if (finish) begin
      granted_r <= pend_grant_r;
      handle_r  <= pend_grant_r ? gh : '0;
      class_r   <= pend_grant_r ? g_own : '0;
      slot_r    <= pend_grant_r ? g_slot[SLOT_W-1:0] : '0;
      cap_r     <= pend_grant_r ? size_r[g_own] : '0;
      status_r  <= pend_status_r;
      huge_r    <= occ_r[NCLASS-1] != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_FILL;
      out_valid_r <= 1'b0;
      size_r[0]   <= SMALL_SIZE_RST;
      size_r[1]   <= MEDIUM_SIZE_RST;
      size_r[2]   <= LARGE_SIZE_RST;
      size_r[3]   <= HUGE_SIZE_RST;
      for (int c = 0; c < NCLASS; c++) begin
        count_r[c] <= COUNT_RST;
        head_r[c]  <= '0;
        tail_r[c]  <= '0;
        occ_r[c]   <= '0;
        wcnt_r[c]  <= '0;
      end
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= finish || (out_valid_r && out_stall);
      for (int c = 0; c < NCLASS; c++) begin
        head_r[c] <= head_nxt[c];
        tail_r[c] <= tail_nxt[c];
        occ_r[c]  <= occ_nxt[c];
        wcnt_r[c] <= wcnt_nxt[c];
      end
      if (cfg_we) begin
        case (cfg_index) inside
          REG_SMALL_SIZE, REG_MEDIUM_SIZE, REG_LARGE_SIZE, REG_HUGE_SIZE:
            size_r[cfg_index[CLASS_W-1:0]] <= cfg_data & SIZE_MASK;
          REG_SMALL_COUNT, REG_MEDIUM_COUNT, REG_LARGE_COUNT, REG_HUGE_COUNT:
            count_r[cfg_index[CLASS_W-1:0]] <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_granted        = granted_r;
  assign out_grant_handle   = handle_r;
  assign out_grant_class    = class_r;
  assign out_grant_slot     = slot_r;
  assign out_grant_capacity = cap_r;
  assign out_status         = status_r;
  assign out_huge_available = huge_r;

endmodule
